// ===== src/tet_pkg.sv =====
`timescale 1ns / 1ps
package tet_pkg;
  localparam int DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF = 48;
  localparam int ID_BITS_DEF = 16;
  localparam int ORDER_BITS = 16;

  typedef enum logic [1:0] {
    REQ_REGISTER = 2'd0,
    REQ_DELETE   = 2'd1,
    REQ_CHECK    = 2'd2,
    REQ_COLLECT  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DUP      = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture request
    logic scan;     // one slot per cycle: match and free slot
    logic scan_clr; // start of a scan pass
    logic apply;    // commit register or delete
    logic pick_clr; // start of a collect selection pass
    logic pick;     // compare one slot against current best
    logic emit;     // retire current best into output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic pick_done;
    logic more;     // selection pass saw a second candidate
  } stat_t;
endpackage

// ===== src/tet_datapath.sv =====
`timescale 1ns / 1ps
module tet_datapath #(
  parameter int DEPTH = tet_pkg::DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tet_pkg::cmd_t        cmd,
  output tet_pkg::stat_t       stat,
  input  logic [1:0]           req_type,
  input  logic [15:0]          timer_id,
  input  logic [47:0]          expiry_time,
  input  logic [7:0]           priority_req,
  output logic [1:0]           status,
  output logic                 is_registered,
  output logic                 item_valid,
  output logic [15:0]          timer_id_out,
  output logic [7:0]           priority_out,
  output logic [4:0]           entry_count,
  output logic                 next_valid,
  output logic [47:0]          next_expiry
);
  localparam int TIME_BITS = tet_pkg::TIME_BITS_DEF;
  localparam int ID_BITS = tet_pkg::ID_BITS_DEF;
  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int OB = tet_pkg::ORDER_BITS;

  logic [DEPTH-1:0]     slot_valid;
  logic [DEPTH-1:0]     slot_done;
  logic [ID_BITS-1:0]   slot_id [DEPTH];
  logic [TIME_BITS-1:0] slot_expiry [DEPTH];
  logic [7:0]           slot_priority [DEPTH];
  logic [OB-1:0]        slot_order [DEPTH];
  logic [OB-1:0]        order_counter;
  logic [CW-1:0]        live_count;

  logic [1:0]           rq;
  logic [ID_BITS-1:0]   rid;
  logic [TIME_BITS-1:0] rt;
  logic [7:0]           rprio;

  logic [IW:0]          idx;
  logic                 hit, has_free;
  logic [IW-1:0]        hit_idx, free_idx;
  logic                 any;
  logic [TIME_BITS-1:0] earliest;

  logic                 best_ok, more;
  logic [IW-1:0]        best_idx;
  logic [7:0]           best_prio;
  logic [OB-1:0]        best_age;

  logic [IW-1:0]        i;
  logic                 cand, better;
  logic [OB-1:0]        age;

  assign i = idx[IW-1:0];
  assign age = order_counter - slot_order[i];
  assign cand = slot_valid[i] && !slot_done[i] && slot_expiry[i] == rt;
  // equal priority goes to the older entry; lower index wins full ties, which the ascending sweep gives for free
  assign better = !best_ok || slot_priority[i] > best_prio ||
                  (slot_priority[i] == best_prio && age > best_age);

  assign stat.scan_done = idx == {1'b0, IW'(DEPTH - 1)};
  assign stat.pick_done = idx == {1'b0, IW'(DEPTH - 1)};
  assign stat.more = more;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      order_counter <= '0;
      live_count <= '0;
      idx <= '0;
      item_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        rq <= req_type;
        rid <= timer_id[ID_BITS-1:0];
        rt <= expiry_time[TIME_BITS-1:0];
        rprio <= priority_req;
        slot_done <= '0;
      end
      if (cmd.scan_clr || cmd.pick_clr) begin
        idx <= '0;
        hit <= 1'b0;
        has_free <= 1'b0;
        best_ok <= 1'b0;
        more <= 1'b0;
      end else if (cmd.scan) begin
        idx <= idx + 1'b1;
        if (slot_valid[i] && slot_id[i] == rid && slot_expiry[i] == rt && !hit) begin
          hit <= 1'b1;
          hit_idx <= i;
        end
        if (!slot_valid[i] && !has_free) begin
          has_free <= 1'b1;
          free_idx <= i;
        end
      end else if (cmd.pick) begin
        idx <= idx + 1'b1;
        if (cand && better) begin
          best_ok <= 1'b1;
          best_idx <= i;
          best_prio <= slot_priority[i];
          best_age <= age;
        end
        if (cand && best_ok) more <= 1'b1;
      end
      if (cmd.apply) begin
        is_registered <= (tet_pkg::req_t'(rq) == tet_pkg::REQ_CHECK) && hit;
        item_valid <= 1'b0;
        timer_id_out <= '0;
        priority_out <= '0;
        case (tet_pkg::req_t'(rq))
          tet_pkg::REQ_REGISTER: begin
            if (hit) status <= tet_pkg::ST_DUP;
            else if (!has_free) status <= tet_pkg::ST_FULL;
            else begin
              status <= tet_pkg::ST_OK;
              slot_valid[free_idx] <= 1'b1;
              slot_id[free_idx] <= rid;
              slot_expiry[free_idx] <= rt;
              slot_priority[free_idx] <= rprio;
              slot_order[free_idx] <= order_counter;
              order_counter <= order_counter + 1'b1;
              live_count <= live_count + 1'b1;
            end
          end
          tet_pkg::REQ_DELETE: begin
            if (hit) begin
              status <= tet_pkg::ST_OK;
              slot_valid[hit_idx] <= 1'b0;
              live_count <= live_count - 1'b1;
            end else status <= tet_pkg::ST_NOTFOUND;
          end
          tet_pkg::REQ_CHECK: status <= tet_pkg::ST_OK;
          default: status <= tet_pkg::ST_OK;
        endcase
      end
      if (cmd.emit) begin
        status <= tet_pkg::ST_OK;
        is_registered <= 1'b0;
        item_valid <= best_ok;
        timer_id_out <= best_ok ? 16'(slot_id[best_idx]) : '0;
        priority_out <= best_ok ? slot_priority[best_idx] : '0;
        if (best_ok) slot_done[best_idx] <= 1'b1;
      end
    end
  end

  // earliest expiry: tracked over the slots after each change, one slot a cycle
  logic [IW-1:0]        e_idx;
  logic                 e_any;
  logic [TIME_BITS-1:0] e_min;
  logic                 e_take;
  assign e_take = slot_valid[e_idx] && (!e_any || slot_expiry[e_idx] < e_min);
  always_ff @(posedge clk) begin
    if (rst) begin
      e_idx <= '0;
      e_any <= 1'b0;
      any <= 1'b0;
    end else begin
      if (cmd.apply || cmd.load) begin
        e_idx <= '0;
        e_any <= 1'b0;
      end else if (e_idx == IW'(DEPTH - 1)) begin
        e_idx <= '0;
        any <= e_any || slot_valid[e_idx];
        earliest <= e_take ? slot_expiry[e_idx] : e_min;
        e_any <= 1'b0;
      end else begin
        e_idx <= e_idx + 1'b1;
        if (e_take) begin
          e_any <= 1'b1;
          e_min <= slot_expiry[e_idx];
        end
      end
    end
  end

  assign entry_count = 5'(live_count);
  assign next_valid = any;
  assign next_expiry = any ? 48'(earliest) : '0;
endmodule

// ===== src/tet_ctrl.sv =====
`timescale 1ns / 1ps
module tet_ctrl #(
  parameter int DEPTH = tet_pkg::DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     req_type,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           last,
  output tet_pkg::cmd_t  cmd,
  input  tet_pkg::stat_t stat
);
  localparam int WW = $clog2(DEPTH + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_SCAN  = 8'b00000010,
    S_APPLY = 8'b00000100,
    S_SUM   = 8'b00001000,
    S_PICK  = 8'b00010000,
    S_EMIT  = 8'b00100000,
    S_OUT   = 8'b01000000,
    S_LAST  = 8'b10000000
  } state_t;

  state_t state, state_next;
  logic [WW-1:0] wait_cnt;

  assign in_stall = state != S_IDLE;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        cmd.scan_clr = 1'b1;
        state_next = (tet_pkg::req_t'(req_type) == tet_pkg::REQ_COLLECT) ? S_PICK : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: if (wait_cnt == '0) state_next = S_LAST;
      S_PICK: begin
        cmd.pick = 1'b1;
        if (stat.pick_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: if (!out_stall) begin
        if (last) state_next = S_IDLE;
        else begin
          cmd.pick_clr = 1'b1;
          state_next = S_PICK;
        end
      end
      S_LAST: if (!out_stall || !out_valid) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // A pick pass also tells whether another match remains, so the collect item
  // goes out with its last flag already known.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      last <= 1'b0;
      wait_cnt <= '0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == S_APPLY) wait_cnt <= WW'(DEPTH);
      else if (wait_cnt != '0) wait_cnt <= wait_cnt - 1'b1;
      if (state == S_SUM && wait_cnt == '0) begin
        out_valid <= 1'b1;
        last <= 1'b1;
      end
      if (state == S_EMIT) begin
        out_valid <= 1'b1;
        last <= !stat.more;
      end
    end
  end
endmodule

// ===== src/timer_expiry_table.sv =====
`timescale 1ns / 1ps
// timer_expiry_table: bounded timer table with ordered collect.
// Sequence: a register/delete/check runs one scan pass, then waits out one pass that
// refreshes the earliest expiry before its result; a collect runs one pick pass per
// result. Only one request is handled at a time; out_stall holds a result until taken.
// Reset: rst (synchronous) empties the table and clears the order stamp and count.
module timer_expiry_table #(
  parameter int DEPTH = tet_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [15:0] timer_id,
  input  logic [47:0] expiry_time,
  input  logic [7:0]  priority_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        is_registered,
  output logic        item_valid,
  output logic [15:0] timer_id_out,
  output logic [7:0]  priority_out,
  output logic        last,
  output logic [4:0]  entry_count,
  output logic        next_valid,
  output logic [47:0] next_expiry
);
  tet_pkg::cmd_t  cmd;
  tet_pkg::stat_t stat;

  // Control: takes one request transfer, sequences scan, apply and pick passes,
  // and owns the result handshake. Input stays stalled until the final result
  // of the request has been transferred.
  tet_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .req_type,
    .out_valid, .out_stall, .last,
    .cmd, .stat
  );

  // Datapath: holds the table and the result fields. Result fields are registers
  // that only change on apply or emit, so they hold while a transfer is stalled.
  // Entry count is read straight from the table state; earliest expiry is a register kept by a background sweep.
  tet_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk, .rst, .cmd, .stat,
    .req_type, .timer_id, .expiry_time, .priority_req,
    .status, .is_registered, .item_valid,
    .timer_id_out, .priority_out,
    .entry_count, .next_valid, .next_expiry
  );
endmodule
